@@ sv/mapd_pkg.sv @@
`default_nettype none

package mapd_pkg;

   localparam int MAX_WINDOW_DEF = 1024;
   localparam int PRICE_W        = 32;
   localparam int DEV_W          = 32;
   localparam int LEN_W          = 11;
   localparam int SUM_W          = PRICE_W + LEN_W;
   localparam int DEN_W          = PRICE_W + LEN_W;
   localparam int FRAC_W         = 16;
   localparam int QUO_W          = 33;
   localparam int CNT_W          = 6;

   localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(900);
   localparam logic [DEV_W-1:0] DEV_MAX      = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] ONE_Q16      = 33'h0_0001_0000;
   localparam logic [QUO_W-1:0] QUO_SAT      = 33'h0_8000_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ sv/moving_average_price_deviation.sv @@
// Moving-average price deviation.
// req channel: one transfer per price sample; req_tdata holds the unsigned
// Q16.16 price, req_tuser the first-of-series flag (restart the window).
// rsp channel: once the window holds W samples, each sample yields one
// transfer; rsp_tdata holds the signed Q16.16 deviation avg/price - 1,
// saturated, rsp_tuser flags a zero newest price.
// csr channel: one transfer writes window_len and restarts the window fill.
// Steps: a sample that yields a result occupies the block through these steps:
// accept, ring read, sum update with the W*price multiply, overflow check,
// 33 steps of the restoring divider (one quotient bit per cycle), result
// load, which waits until the output register is free. rsp_tvalid rises as
// the result loads, and the next sample can be accepted once the block is
// idle again; req_tready is low from accept until the result loads. A ratio
// beyond the divider range skips it; samples that produce no result return
// to idle after the sum update, and zero prices skip the check and divider.
// Reset: window_len returns to 900 and the window is empty; the ring needs
// no clearing pass since no entry is read before it is written.
// Stall: the result sits in the output register until taken; the next item
// is accepted meanwhile and waits for the register before loading its own.
`default_nettype none

module moving_average_price_deviation #(
   parameter int MAX_WINDOW = mapd_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [mapd_pkg::PRICE_W-1:0] req_tdata,   // [31:0] price
   input  wire logic                         req_tuser,   // [0] first_of_series
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [mapd_pkg::DEV_W-1:0]        rsp_tdata,   // [31:0] deviation
   output logic                              rsp_tuser,   // [0] zero_price
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [mapd_pkg::LEN_W-1:0]   csr_data
);

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   mapd_pkg::state_type state_ff, state_in;

   logic [mapd_pkg::LEN_W-1:0]   window_len_ff, window_len_in;
   logic [mapd_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [mapd_pkg::LEN_W-1:0]   fill_ff, fill_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [mapd_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [mapd_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [mapd_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [mapd_pkg::QUO_W-1:0]   qr_ff, qr_in;
   logic [mapd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         sat_ff, sat_in;
   logic                         zero_ff, zero_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mapd_pkg::DEV_W-1:0]   rsp_dev_ff, rsp_dev_in;
   logic                         rsp_zero_ff, rsp_zero_in;

   logic [mapd_pkg::PRICE_W-1:0] ring_mem [MAX_WINDOW];
   logic [mapd_pkg::PRICE_W-1:0] ring_rd_ff;
   logic [PTR_W-1:0]             ring_raddr;
   logic                         ring_we;

   logic [mapd_pkg::LEN_W-1:0]   w_eff;
   logic [31:0]                  old_calc;
   logic                         full;
   logic                         req_xfer;
   logic                         csr_xfer;
   logic                         out_free;
   logic [mapd_pkg::DEN_W:0]     trial;
   logic                         qbit;
   logic [mapd_pkg::DEV_W-1:0]   dev_val;

   assign req_tready = (state_ff == mapd_pkg::ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == mapd_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dev_ff;
   assign rsp_tuser  = rsp_zero_ff;

   always_comb begin
      if (window_len_ff == '0) begin
         w_eff = mapd_pkg::LEN_W'(1);
      end else if (32'(window_len_ff) > 32'(MAX_WINDOW)) begin
         w_eff = mapd_pkg::LEN_W'(MAX_WINDOW);
      end else begin
         w_eff = window_len_ff;
      end
   end

   assign full = (fill_ff >= w_eff);

   always_comb begin
      if (32'(wp_ff) >= 32'(w_eff)) begin
         old_calc = 32'(wp_ff) - 32'(w_eff);
      end else begin
         old_calc = 32'(wp_ff) + 32'(MAX_WINDOW) - 32'(w_eff);
      end
   end

   assign ring_raddr = old_calc[PTR_W-1:0];
   assign ring_we    = (state_ff == mapd_pkg::ST_UPDATE);

   assign trial = {rem_ff, qr_ff[mapd_pkg::QUO_W-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      if (zero_ff || sat_ff || (qr_ff >= mapd_pkg::QUO_SAT)) begin
         dev_val = mapd_pkg::DEV_MAX;
      end else begin
         dev_val = mapd_pkg::DEV_W'(qr_ff - mapd_pkg::ONE_Q16);
      end
   end

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      wp_in         = wp_ff;
      price_in      = price_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      qr_in         = qr_ff;
      cnt_in        = cnt_ff;
      sat_in        = sat_ff;
      zero_in       = zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_dev_in    = rsp_dev_ff;
      rsp_zero_in   = rsp_zero_ff;

      case (state_ff)
         mapd_pkg::ST_IDLE: begin
            if (csr_xfer) begin
               window_len_in = csr_data;
               sum_in        = '0;
               fill_in       = '0;
               wp_in         = '0;
            end else if (req_xfer) begin
               price_in = req_tdata;
               if (req_tuser) begin
                  sum_in  = '0;
                  fill_in = '0;
                  wp_in   = '0;
               end
               state_in = mapd_pkg::ST_READ;
            end
         end
         mapd_pkg::ST_READ: begin
            state_in = mapd_pkg::ST_UPDATE;
         end
         mapd_pkg::ST_UPDATE: begin
            if (full) begin
               sum_in = sum_ff - mapd_pkg::SUM_W'(ring_rd_ff)
                        + mapd_pkg::SUM_W'(price_ff);
            end else begin
               sum_in  = sum_ff + mapd_pkg::SUM_W'(price_ff);
               fill_in = fill_ff + mapd_pkg::LEN_W'(1);
            end
            if (32'(wp_ff) == 32'(MAX_WINDOW - 1)) begin
               wp_in = '0;
            end else begin
               wp_in = wp_ff + PTR_W'(1);
            end
            den_in  = mapd_pkg::DEN_W'(w_eff) * mapd_pkg::DEN_W'(price_ff);
            zero_in = (price_ff == '0);
            sat_in  = 1'b0;
            if (!full && ((fill_ff + mapd_pkg::LEN_W'(1)) != w_eff)) begin
               state_in = mapd_pkg::ST_IDLE;
            end else if (price_ff == '0) begin
               state_in = mapd_pkg::ST_DONE;
            end else begin
               state_in = mapd_pkg::ST_CHECK;
            end
         end
         mapd_pkg::ST_CHECK: begin
            sat_in = ({17'b0, sum_ff} >= {den_ff, 17'b0});
            rem_in = mapd_pkg::DEN_W'(sum_ff >> 17);
            qr_in  = {sum_ff[16:0], 16'b0};
            cnt_in = '0;
            if ({17'b0, sum_ff} >= {den_ff, 17'b0}) begin
               state_in = mapd_pkg::ST_DONE;
            end else begin
               state_in = mapd_pkg::ST_DIV;
            end
         end
         mapd_pkg::ST_DIV: begin
            if (qbit) begin
               rem_in = mapd_pkg::DEN_W'(trial - {1'b0, den_ff});
            end else begin
               rem_in = trial[mapd_pkg::DEN_W-1:0];
            end
            qr_in  = {qr_ff[mapd_pkg::QUO_W-2:0], qbit};
            cnt_in = cnt_ff + mapd_pkg::CNT_W'(1);
            if (cnt_ff == mapd_pkg::CNT_W'(mapd_pkg::QUO_W - 1)) begin
               state_in = mapd_pkg::ST_DONE;
            end
         end
         mapd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dev_in   = dev_val;
               rsp_zero_in  = zero_ff;
               state_in     = mapd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mapd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mapd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= mapd_pkg::WINDOW_RESET;
         sum_ff        <= '0;
         fill_ff       <= '0;
         wp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         sum_ff        <= sum_in;
         fill_ff       <= fill_in;
         wp_ff         <= wp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      qr_ff       <= qr_in;
      cnt_ff      <= cnt_in;
      sat_ff      <= sat_in;
      zero_ff     <= zero_in;
      rsp_dev_ff  <= rsp_dev_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= price_ff;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= w_eff)
      else $error("fill count above window length");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mapd_pkg::ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < 32'(MAX_WINDOW))
      else $error("write pointer out of ring range");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == mapd_pkg::ST_READ))
      else $error("accepted sample did not start a ring read");

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == mapd_pkg::ST_DONE))
      else $error("result loaded outside the done step");
`endif

endmodule

`default_nettype wire

@@ test/deviation_monitor.sv @@
`timescale 1ns / 100ps

module deviation_monitor (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   input  wire logic [mapd_pkg::PRICE_W-1:0] req_tdata,   // [31:0] price
   input  wire logic                         req_tuser,   // [0] first_of_series
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic [mapd_pkg::DEV_W-1:0]   rsp_tdata,   // [31:0] deviation
   input  wire logic                         rsp_tuser,   // [0] zero_price
   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic [mapd_pkg::LEN_W-1:0]   csr_data,
   output int                                mismatches,
   output int                                outstanding
);

   localparam int unsigned RING_DEPTH = mapd_pkg::MAX_WINDOW_DEF;

   typedef struct packed {
      logic [mapd_pkg::DEV_W-1:0] deviation;
      logic                       zero_price;
   } deviation_result_type;

   logic [mapd_pkg::PRICE_W-1:0] price_ring [RING_DEPTH];
   logic [63:0]                  window_sum;
   int unsigned                  filled;
   int unsigned                  slot;
   logic [mapd_pkg::LEN_W-1:0]   window_len;
   deviation_result_type         deviation_due [$];

   function automatic logic [mapd_pkg::DEV_W-1:0] ratio_deviation(
         input logic [63:0] sum,
         input logic [63:0] width,
         input logic [mapd_pkg::PRICE_W-1:0] price);
      logic [63:0] den;
      logic [63:0] whole;
      logic [63:0] rest;
      logic [63:0] quo;
      den   = width * 64'(price);
      whole = sum / den;
      rest  = sum % den;
      if (whole >= 64'(mapd_pkg::ONE_Q16)) begin
         return mapd_pkg::DEV_MAX;
      end
      quo = (whole << mapd_pkg::FRAC_W) + ((rest << mapd_pkg::FRAC_W) / den);
      if (quo >= 64'(mapd_pkg::DEV_MAX) + 64'(mapd_pkg::ONE_Q16)) begin
         return mapd_pkg::DEV_MAX;
      end
      return mapd_pkg::DEV_W'(quo - 64'(mapd_pkg::ONE_Q16));
   endfunction

   task automatic restart_window();
      window_sum = '0;
      filled     = 0;
      slot       = 0;
   endtask

   task automatic take_sample(input logic [mapd_pkg::PRICE_W-1:0] price,
                              input logic new_series);
      int unsigned          width;
      int unsigned          oldest;
      deviation_result_type due;
      if (window_len == '0) begin
         width = 1;
      end else if (window_len > RING_DEPTH) begin
         width = RING_DEPTH;
      end else begin
         width = window_len;
      end
      if (new_series) begin
         restart_window();
      end
      if (filled >= width) begin
         oldest     = (slot + RING_DEPTH - width) % RING_DEPTH;
         window_sum = window_sum - 64'(price_ring[oldest]);
      end else begin
         filled++;
      end
      price_ring[slot] = price;
      window_sum       = window_sum + 64'(price);
      slot             = (slot + 1) % RING_DEPTH;
      if (filled >= width) begin
         if (price == '0) begin
            due.deviation  = mapd_pkg::DEV_MAX;
            due.zero_price = 1'b1;
         end else begin
            due.deviation  = ratio_deviation(window_sum, 64'(width), price);
            due.zero_price = 1'b0;
         end
         deviation_due = {deviation_due, due};
      end
   endtask

   task automatic check_result(input logic [mapd_pkg::DEV_W-1:0] deviation,
                               input logic zero_price);
      deviation_result_type due;
      if (deviation_due.size() == 0) begin
         $error("unexpected transfer: deviation %0d zero_price %0b",
                $signed(deviation), zero_price);
         mismatches++;
      end else begin
         due = deviation_due.pop_front();
         if (due.deviation !== deviation) begin
            $error("deviation: expected %0d, actual %0d",
                   $signed(due.deviation), $signed(deviation));
            mismatches++;
         end
         if (due.zero_price !== zero_price) begin
            $error("zero_price: expected %0b, actual %0b", due.zero_price, zero_price);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_len = mapd_pkg::WINDOW_RESET;
         restart_window();
         deviation_due.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_len = csr_data;
            restart_window();
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata, rsp_tuser);
         end
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata, req_tuser);
         end
      end
      outstanding = deviation_due.size();
   end

endmodule

@@ test/tb_moving_average_price_deviation.sv @@
`timescale 1ns / 100ps

module tb_moving_average_price_deviation;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 60;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [mapd_pkg::PRICE_W-1:0] req_tdata;   // [31:0] price
   logic                         req_tuser;   // [0] first_of_series
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [mapd_pkg::DEV_W-1:0]   rsp_tdata;   // [31:0] deviation
   logic                         rsp_tuser;   // [0] zero_price
   logic                         csr_valid;
   logic                         csr_ready;
   logic [mapd_pkg::LEN_W-1:0]   csr_data;
   int                           mismatches;
   int                           outstanding;
   bit                           no_gaps;

   moving_average_price_deviation u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   deviation_monitor u_deviation_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [mapd_pkg::PRICE_W-1:0] pick_price(
         input logic [mapd_pkg::PRICE_W-1:0] base);
      int roll;
      roll = $urandom_range(0, 19);
      case (roll)
         0: begin
            return '0;
         end
         1: begin
            return $urandom;
         end
         2: begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
         end
         default: begin
            return base + $urandom_range(0, base >> 3) - (base >> 4);
         end
      endcase
   endfunction

   task automatic send_sample(input logic [mapd_pkg::PRICE_W-1:0] price,
                              input logic new_series);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      req_tuser  <= new_series;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_window(input logic [mapd_pkg::LEN_W-1:0] length);
      drain(SETTLE);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= length;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [mapd_pkg::LEN_W-1:0] length, input int count,
                            input int restart_odds);
      logic [mapd_pkg::PRICE_W-1:0] base;
      logic                         new_series;
      base    = $urandom_range(32'h0001_0000, 32'h0FFF_0000);
      no_gaps = ($urandom_range(0, 3) == 0);
      write_window(length);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            drain(0);
         end
         new_series = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
         send_sample(pick_price(base), new_series);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin : ready_pattern
         int roll;
         int span;
         logic level;
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            level = 1'b1;
            span  = $urandom_range(1, 10);
         end else if (roll < 88) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else if (roll < 95) begin
            level = 1'b0;
            span  = $urandom_range(10, 40);
         end else begin
            level = 1'b1;
            span  = $urandom_range(50, 150);
         end
         rsp_tready <= level;
         repeat (span - 1) @(negedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb_moving_average_price_deviation NOT OK");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      no_gaps    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two-sample window: flat, saturated ratio, zero price, near-minimum, restart
      write_window(mapd_pkg::LEN_W'(2));
      send_sample(32'h0001_0000, 1'b1);
      send_sample(32'h0001_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0005, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h1234_5678, 1'b1);
      send_sample(32'h2345_6789, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);

      // zero length behaves as a one-sample window
      write_window(mapd_pkg::LEN_W'(0));
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b1);
      send_sample(32'h8000_0000, 1'b0);

      run_phase(mapd_pkg::LEN_W'(1), 40, 40);
      run_phase(mapd_pkg::LEN_W'(3), 50, 40);
      run_phase(mapd_pkg::LEN_W'(0), 30, 40);
      run_phase(mapd_pkg::LEN_W'(16), 60, 60);
      run_phase(mapd_pkg::LEN_W'(5), 50, 40);
      run_phase(mapd_pkg::LEN_W'(64), 100, 0);
      run_phase(mapd_pkg::LEN_W'(2047), 1040, 0);

      drain(SETTLE);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_moving_average_price_deviation OK");
      end else begin
         $display("tb_moving_average_price_deviation NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mapd_pkg.sv
sv/moving_average_price_deviation.sv
test/deviation_monitor.sv
test/tb_moving_average_price_deviation.sv
